FILE: sv/ipv_pkg.sv
// Shared types, constants and the divide-by-100 helper of the PID velocity block.
`default_nettype none

package ipv_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PROP_GAIN      = 3'd0,
    REG_INT_GAIN       = 3'd1,
    REG_DERIV_GAIN     = 3'd2,
    REG_INTEGRAL_LIMIT = 3'd3,
    REG_OUTPUT_LIMIT   = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic signed [15:0] prop_gain;
    logic signed [15:0] int_gain;
    logic signed [15:0] deriv_gain;
    logic        [14:0] integral_limit;
    logic        [14:0] output_limit;
  } cfg_t;

  localparam logic signed [15:0] PROP_GAIN_RST      = 16'sd600;
  localparam logic signed [15:0] INT_GAIN_RST       = 16'sd0;
  localparam logic signed [15:0] DERIV_GAIN_RST     = 16'sd400;
  localparam logic        [14:0] INTEGRAL_LIMIT_RST = 15'd1000;
  localparam logic        [14:0] OUTPUT_LIMIT_RST   = 15'd2000;

  // Bias that makes the gain sum non-negative: 100 * 2**27.
  localparam logic [34:0] DIV_OFFSET = 35'd13421772800;
  // Quotient of the bias, removed after the division.
  localparam logic [29:0] QUO_BIAS   = 30'd134217728;
  // Split point of the biased sum into high and low digits.
  localparam int          DIV_SPLIT  = 18;
  // ceil(2**32 / 100); exact floor quotient for any input below 2**30.
  localparam logic [25:0] DIV100_RECIP = 26'd42949673;
  localparam logic [24:0] DIVISOR      = 25'd100;

  typedef struct packed {
    logic [18:0] quo;
    logic [6:0]  rem;
  } div100_t;

  // Floor quotient and remainder of a 25-bit value by 100.
  function automatic div100_t div100(input logic [24:0] x);
    logic [50:0] prod;
    logic [18:0] q;
    logic [24:0] r;
    div100_t     res;
    prod = 51'(x) * 51'(DIV100_RECIP);
    q    = prod[50:32];
    r    = x - 25'(q) * DIVISOR;
    if (r >= DIVISOR) begin
      q = q + 19'd1;
      r = r - DIVISOR;
    end
    res.quo = q;
    res.rem = r[6:0];
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: sv/ipv_regs.sv
// Configuration register file of the PID velocity block.
`default_nettype none

module ipv_regs (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               wr_en,
  input  wire logic [ipv_pkg::CFG_INDEX_W-1:0]    wr_index,
  input  wire logic [ipv_pkg::CFG_DATA_W-1:0]     wr_data,
  output      ipv_pkg::cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain      <= ipv_pkg::PROP_GAIN_RST;
      cfg.int_gain       <= ipv_pkg::INT_GAIN_RST;
      cfg.deriv_gain     <= ipv_pkg::DERIV_GAIN_RST;
      cfg.integral_limit <= ipv_pkg::INTEGRAL_LIMIT_RST;
      cfg.output_limit   <= ipv_pkg::OUTPUT_LIMIT_RST;
    end else if (wr_en) begin
      case (ipv_pkg::reg_index_t'(wr_index))
        ipv_pkg::REG_PROP_GAIN:      cfg.prop_gain      <= wr_data;
        ipv_pkg::REG_INT_GAIN:       cfg.int_gain       <= wr_data;
        ipv_pkg::REG_DERIV_GAIN:     cfg.deriv_gain     <= wr_data;
        ipv_pkg::REG_INTEGRAL_LIMIT: cfg.integral_limit <= wr_data[14:0];
        ipv_pkg::REG_OUTPUT_LIMIT:   cfg.output_limit   <= wr_data[14:0];
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sv/incremental_pid_velocity_4ch_unit.sv
// Top level of the multi-channel incremental PID velocity controller.
//
// Usage: each input word on in_valid/in_ready names a motor channel and
// carries a target and a measured speed; one output word per input word
// returns the channel's new saturated drive value on out_valid/out_ready.
// Gains and limits are written on cfg_valid/cfg_ready (cfg_index, cfg_data)
// while no word is in flight; cfg_ready is always high.
// Throughput: one word per cycle while out_ready does not hold the pipe,
// any mix of channels; each per-channel state field is read and written in
// a single stage, so back-to-back words on one channel see each other's
// updates. The pipeline is input register, error/integral update, three
// gain products, sum, two divide-by-100 digit stages, then drive update.
// Stalls: a stage holds only while its successor is full and held, so
// bubbles close up and in_ready stays high until the whole pipe fills.
// A channel index of CHANNELS or more returns 0 and leaves all state alone.
// Reset loads the default gains and limits and clears all channel state.
`default_nettype none

module incremental_pid_velocity_4ch_unit #(
  parameter int CHANNELS = 4
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output      logic                                in_ready,
  input  wire logic [1:0]                          motor_index,
  input  wire logic signed [15:0]                  target_speed,
  input  wire logic signed [15:0]                  measured_speed,
  output      logic                                out_valid,
  input  wire logic                                out_ready,
  output      logic signed [15:0]                  drive_value,
  input  wire logic                                cfg_valid,
  output      logic                                cfg_ready,
  input  wire logic [ipv_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [ipv_pkg::CFG_DATA_W-1:0]      cfg_data
);

  ipv_pkg::cfg_t cfg;

  assign cfg_ready = 1'b1;

  ipv_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Stage valids: 0 input, 1 error, 2 products, 3 sum, 4 high digit, 5 low digit.
  logic [5:0] vld;
  logic [6:0] adv;

  always_comb begin
    adv[6] = !out_valid || out_ready;
    for (int k = 5; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (adv[0]) vld[0] <= in_valid;
      for (int k = 1; k < 6; k++) begin
        if (adv[k]) vld[k] <= vld[k-1];
      end
      if (adv[6]) out_valid <= vld[5];
    end
  end

  // Per-channel state
  logic signed [16:0] prev_error [CHANNELS];
  logic signed [15:0] error_sum  [CHANNELS];
  logic signed [15:0] drive_hold [CHANNELS];

  // Stage 0: input register
  logic [1:0]         ch0;
  logic signed [15:0] tgt0;
  logic signed [15:0] meas0;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      ch0   <= motor_index;
      tgt0  <= target_speed;
      meas0 <= measured_speed;
    end
  end

  // Stage 1: error, clamped integral, error delta
  logic               hit0;
  logic signed [16:0] perr_cur;
  logic signed [15:0] esum_cur;
  logic signed [16:0] e_next;
  logic signed [17:0] dlt_next;
  logic signed [17:0] sum_raw;
  logic signed [17:0] ilim;
  logic signed [15:0] sum_next;
  logic               wr_err;

  always_comb begin
    perr_cur = '0;
    esum_cur = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (int'(ch0) == i) begin
        perr_cur = prev_error[i];
        esum_cur = error_sum[i];
      end
    end
  end

  assign hit0     = int'(ch0) < CHANNELS;
  assign e_next   = 17'(tgt0) - 17'(meas0);
  assign dlt_next = 18'(e_next) - 18'(perr_cur);
  assign sum_raw  = 18'(esum_cur) + 18'(e_next);
  assign ilim     = 18'(cfg.integral_limit);

  always_comb begin
    if (sum_raw > ilim) begin
      sum_next = 16'(ilim);
    end else if (sum_raw < -ilim) begin
      sum_next = 16'(-ilim);
    end else begin
      sum_next = 16'(sum_raw);
    end
  end

  assign wr_err = adv[1] && vld[0] && hit0;

  logic [1:0]         ch1;
  logic               hit1;
  logic signed [16:0] e1;
  logic signed [17:0] dlt1;
  logic signed [15:0] sum1;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      ch1  <= ch0;
      hit1 <= hit0;
      e1   <= e_next;
      dlt1 <= dlt_next;
      sum1 <= sum_next;
    end
  end

  // Stage 2: gain products
  logic [1:0]         ch2;
  logic               hit2;
  logic signed [32:0] pe2;
  logic signed [33:0] de2;
  logic signed [31:0] ie2;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      ch2  <= ch1;
      hit2 <= hit1;
      pe2  <= 33'(cfg.prop_gain) * 33'(e1);
      de2  <= 34'(cfg.deriv_gain) * 34'(dlt1);
      ie2  <= 32'(cfg.int_gain) * 32'(sum1);
    end
  end

  // Stage 3: gain sum, biased non-negative for the division
  logic signed [33:0] gsum;
  logic [1:0]         ch3;
  logic               hit3;
  logic [34:0]        soff3;

  assign gsum = 34'(pe2) + de2 + 34'(ie2);

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      ch3   <= ch2;
      hit3  <= hit2;
      soff3 <= 35'(gsum) + ipv_pkg::DIV_OFFSET;
    end
  end

  // Stage 4: divide the high digit by 100
  ipv_pkg::div100_t dv_hi;
  logic [1:0]       ch4;
  logic             hit4;
  logic [10:0]      qh4;
  logic [6:0]       rh4;
  logic [17:0]      lo4;

  assign dv_hi = ipv_pkg::div100(25'(soff3[34:ipv_pkg::DIV_SPLIT]));

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      ch4  <= ch3;
      hit4 <= hit3;
      qh4  <= dv_hi.quo[10:0];
      rh4  <= dv_hi.rem;
      lo4  <= soff3[ipv_pkg::DIV_SPLIT-1:0];
    end
  end

  // Stage 5: divide the remainder with the low digit, remove the bias
  ipv_pkg::div100_t   dv_lo;
  logic [29:0]        quo_biased;
  logic [1:0]         ch5;
  logic               hit5;
  logic signed [27:0] q5;
  logic [6:0]         r5;

  assign dv_lo      = ipv_pkg::div100({rh4, lo4});
  assign quo_biased = {1'b0, qh4, dv_lo.quo[17:0]} - ipv_pkg::QUO_BIAS;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      ch5  <= ch4;
      hit5 <= hit4;
      q5   <= quo_biased[27:0];
      r5   <= dv_lo.rem;
    end
  end

  // Stage 6: drive = trunc((100*hold + S) / 100), saturated
  logic signed [15:0] dh_cur;
  logic signed [28:0] tsum;
  logic signed [28:0] tadj;
  logic signed [28:0] olim;
  logic signed [15:0] drv_next;
  logic               wr_drv;

  always_comb begin
    dh_cur = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (int'(ch5) == i) begin
        dh_cur = drive_hold[i];
      end
    end
  end

  assign tsum = 29'(dh_cur) + 29'(q5);
  // floor to truncation: step up for a negative quotient with a remainder
  assign tadj = (tsum[28] && (r5 != '0)) ? tsum + 29'sd1 : tsum;
  assign olim = 29'(cfg.output_limit);

  always_comb begin
    if (tadj > olim) begin
      drv_next = 16'(olim);
    end else if (tadj < -olim) begin
      drv_next = 16'(-olim);
    end else begin
      drv_next = 16'(tadj);
    end
  end

  assign wr_drv = adv[6] && vld[5] && hit5;

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      drive_value <= hit5 ? drv_next : '0;
    end
  end

  // Channel state update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        prev_error[i] <= '0;
        error_sum[i]  <= '0;
        drive_hold[i] <= '0;
      end
    end else begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (wr_err && int'(ch0) == i) begin
          prev_error[i] <= e_next;
          error_sum[i]  <= sum_next;
        end
        if (wr_drv && int'(ch5) == i) begin
          drive_hold[i] <= drv_next;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: test/ipv_drive_checker.sv
// Checker for the PID velocity block: predicts each drive word and compares it.
`timescale 1ns / 100ps

module ipv_drive_checker #(
  parameter int CHANNELS = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic [1:0]                       motor_index,
  input  logic signed [15:0]               target_speed,
  input  logic signed [15:0]               measured_speed,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic signed [15:0]               drive_value,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [ipv_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [ipv_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                               mismatch_count,
  output int                               words_in_flight
);

  localparam int MAX_REPORTS = 10;

  logic signed [15:0] kp;
  logic signed [15:0] ki;
  logic signed [15:0] kd;
  logic        [14:0] int_limit;
  logic        [14:0] out_limit;

  logic signed [16:0] last_err   [CHANNELS];
  logic signed [15:0] err_acc    [CHANNELS];
  logic signed [15:0] drive_hold [CHANNELS];

  logic signed [15:0] expected_drive [$];

  initial mismatch_count = 0;
  initial words_in_flight = 0;

  function automatic longint limit_sym(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Run one controller update on the channel's state and return the new drive.
  function automatic logic signed [15:0] advance_channel(input logic [1:0] ch,
                                                         input logic signed [15:0] tgt,
                                                         input logic signed [15:0] meas);
    longint err;
    longint acc;
    longint gain_sum;
    longint drv;
    if (ch >= CHANNELS) return '0;
    err = longint'(tgt) - longint'(meas);
    acc = limit_sym(longint'(err_acc[ch]) + err, longint'(int_limit));
    gain_sum = longint'(kp) * err
             + longint'(kd) * (err - longint'(last_err[ch]))
             + longint'(ki) * acc;
    // signed divide truncates toward zero
    drv = (100 * longint'(drive_hold[ch]) + gain_sum) / 100;
    drv = limit_sym(drv, longint'(out_limit));
    err_acc[ch]    = 16'(acc);
    last_err[ch]   = 17'(err);
    drive_hold[ch] = 16'(drv);
    return 16'(drv);
  endfunction

  task automatic note_miss(input string what, input logic signed [15:0] want,
                           input logic signed [15:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
  endtask

  always @(posedge clk) begin
    logic signed [15:0] want;
    if (rst) begin
      kp        = ipv_pkg::PROP_GAIN_RST;
      ki        = ipv_pkg::INT_GAIN_RST;
      kd        = ipv_pkg::DERIV_GAIN_RST;
      int_limit = ipv_pkg::INTEGRAL_LIMIT_RST;
      out_limit = ipv_pkg::OUTPUT_LIMIT_RST;
      for (int c = 0; c < CHANNELS; c++) begin
        last_err[c]   = '0;
        err_acc[c]    = '0;
        drive_hold[c] = '0;
      end
      expected_drive.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ipv_pkg::REG_PROP_GAIN:      kp = signed'(cfg_data);
          ipv_pkg::REG_INT_GAIN:       ki = signed'(cfg_data);
          ipv_pkg::REG_DERIV_GAIN:     kd = signed'(cfg_data);
          ipv_pkg::REG_INTEGRAL_LIMIT: int_limit = cfg_data[14:0];
          ipv_pkg::REG_OUTPUT_LIMIT:   out_limit = cfg_data[14:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_drive.push_back(advance_channel(motor_index, target_speed, measured_speed));
      if (out_valid && out_ready) begin
        if (expected_drive.size() == 0) begin
          note_miss("drive word with nothing pending", '0, drive_value);
        end else begin
          want = expected_drive.pop_front();
          if (drive_value !== want) note_miss("drive_value mismatch", want, drive_value);
        end
      end
    end
    words_in_flight <= expected_drive.size();
  end

endmodule

FILE: test/incremental_pid_velocity_4ch_unit_tb.sv
// Testbench top for the PID velocity block: clock, reset, traffic and verdict.
`timescale 1ns / 100ps

module incremental_pid_velocity_4ch_unit_tb;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int RX_HOLD_CYCLES  = 120;
  localparam int HOLD_WORDS      = 40;
  localparam int RAND_PHASES     = 10;
  localparam int WORDS_PER_PHASE = 49;
  localparam int TAIL_CYCLES     = 20;
  localparam logic [ipv_pkg::CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd5;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                            in_valid       = 1'b0;
  logic                            in_ready;
  logic [1:0]                      motor_index    = '0;
  logic signed [15:0]              target_speed   = '0;
  logic signed [15:0]              measured_speed = '0;
  logic                            out_valid;
  logic                            out_ready      = 1'b0;
  logic signed [15:0]              drive_value;
  logic                            cfg_valid      = 1'b0;
  logic                            cfg_ready;
  logic [ipv_pkg::CFG_INDEX_W-1:0] cfg_index      = '0;
  logic [ipv_pkg::CFG_DATA_W-1:0]  cfg_data       = '0;

  int mismatch_count;
  int words_in_flight;
  int cycle_count = 0;

  bit tx_quiet    = 1'b0;
  bit rx_quiet    = 1'b0;
  bit rx_hold_req = 1'b0;

  logic signed [15:0] setpoint [4] = '{default: '0};

  always #5 clk = ~clk;

  incremental_pid_velocity_4ch_unit u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .motor_index    (motor_index),
    .target_speed   (target_speed),
    .measured_speed (measured_speed),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .drive_value    (drive_value),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  ipv_drive_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .motor_index     (motor_index),
    .target_speed    (target_speed),
    .measured_speed  (measured_speed),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .drive_value     (drive_value),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .words_in_flight (words_in_flight)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3, 4:    return 16'(int'($urandom_range(0, 2000)) - 1000);
      default: return 16'($urandom);
    endcase
  endfunction

  // Bit 15 is not part of a limit; toggle it anyway.
  function automatic logic [15:0] pick_limit();
    logic [14:0] v;
    case ($urandom_range(0, 5))
      0:       v = '0;
      1:       v = 15'h7FFF;
      2, 3:    v = 15'($urandom_range(1, 3000));
      default: v = 15'($urandom);
    endcase
    return {1'($urandom), v};
  endfunction

  // Receiver: random ready pattern, plus a long hold-off on request.
  initial begin
    int run_left;
    int stall_left;
    run_left = 0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        stall_left = RX_HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (run_left > 0) begin
          run_left--;
        end else begin
          run_left = $urandom_range(0, 15);
          stall_left = rx_quiet ? 0 : idle_len();
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_word(input logic [1:0] ch, input logic signed [15:0] tgt,
                           input logic signed [15:0] meas);
    int gap;
    gap = tx_quiet ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    motor_index    <= ch;
    target_speed   <= tgt;
    measured_speed <= meas;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold input idle until every predicted drive word has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_in_flight != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [ipv_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [ipv_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic cfg_all(input logic [15:0] p, input logic [15:0] i, input logic [15:0] d,
                         input logic [15:0] il, input logic [15:0] ol);
    cfg_write(ipv_pkg::REG_PROP_GAIN, p);
    cfg_write(ipv_pkg::REG_INT_GAIN, i);
    cfg_write(ipv_pkg::REG_DERIV_GAIN, d);
    cfg_write(ipv_pkg::REG_INTEGRAL_LIMIT, il);
    cfg_write(ipv_pkg::REG_OUTPUT_LIMIT, ol);
  endtask

  task automatic configure_phase(input int ph);
    case (ph)
      0:       cfg_all(16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF);
      1:       cfg_all(16'h8000, 16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF);
      2:       cfg_all(ipv_pkg::PROP_GAIN_RST, 16'sd150, ipv_pkg::DERIV_GAIN_RST,
                       {1'b0, ipv_pkg::INTEGRAL_LIMIT_RST},
                       {1'b0, ipv_pkg::OUTPUT_LIMIT_RST});
      default: cfg_all(pick_gain(), pick_gain(), pick_gain(), pick_limit(), pick_limit());
    endcase
    if ($urandom_range(0, 2) == 0)
      cfg_write(3'($urandom_range(REG_SPARE_LO, 2 ** ipv_pkg::CFG_INDEX_W - 1)),
                16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Mostly tracking words around a per-channel setpoint, some full-range noise.
  task automatic send_random();
    logic [1:0]         ch;
    logic signed [15:0] tgt;
    logic signed [15:0] meas;
    ch = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 99) < 35) begin
      tgt  = 16'($urandom);
      meas = 16'($urandom);
    end else begin
      if ($urandom_range(0, 9) == 0)
        setpoint[ch] = 16'(int'($urandom_range(0, 4000)) - 2000);
      tgt  = setpoint[ch];
      meas = tgt + 16'(int'($urandom_range(0, 400)) - 200);
    end
    send_word(ch, tgt, meas);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // default gains: zero, extremes of both signs, small errors
    send_word(2'd0, 16'sd0, 16'sd0);
    send_word(2'd1, 16'sd32767, -16'sd32768);
    send_word(2'd1, 16'sd32767, -16'sd32768);
    send_word(2'd2, -16'sd32768, 16'sd32767);
    send_word(2'd3, 16'sd100, 16'sd90);
    send_word(2'd3, 16'sd100, 16'sd110);
    send_word(2'd0, -16'sd1, 16'sd0);
    send_word(2'd2, 16'sd32767, 16'sd32767);
    send_word(2'd1, 16'sd0, 16'sd0);
    send_word(2'd0, 16'sd1234, -16'sd4321);

    // largest gains and limits: widest intermediates
    wait_drained();
    cfg_all(16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h7FFF);
    cfg_valid <= 1'b0;
    send_word(2'd0, 16'sd32767, -16'sd32768);
    send_word(2'd0, 16'sd32767, -16'sd32768);
    send_word(2'd1, -16'sd32768, 16'sd32767);
    send_word(2'd2, 16'sd32767, -16'sd32768);
    send_word(2'd2, -16'sd32768, 16'sd32767);
    send_word(2'd3, 16'sd5, 16'sd5);
    send_word(2'd0, -16'sd32768, 16'sd32767);
    send_word(2'd1, 16'sd0, 16'sd0);

    // zero limits, and writes to unused indexes that must change nothing
    wait_drained();
    cfg_write(ipv_pkg::REG_INT_GAIN, 16'h7FFF);
    cfg_write(ipv_pkg::REG_INTEGRAL_LIMIT, 16'h0000);
    cfg_write(ipv_pkg::REG_OUTPUT_LIMIT, 16'h8000);
    for (int k = REG_SPARE_LO; k < 2 ** ipv_pkg::CFG_INDEX_W; k++)
      cfg_write(3'(k), 16'hFFFF);
    cfg_valid <= 1'b0;
    send_word(2'd0, 16'sd1000, -16'sd1000);
    send_word(2'd1, -16'sd32768, 16'sd32767);
    send_word(2'd2, 16'sd7, 16'sd0);
    send_word(2'd3, 16'sd32767, -16'sd32768);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_drained();
      configure_phase(ph);
      rx_quiet = ($urandom_range(0, 3) == 0);
      tx_quiet = ($urandom_range(0, 3) == 0);
      if (ph == 2) begin
        // stall the output and keep offering so the pipe fills and backs up
        rx_hold_req = 1'b1;
        tx_quiet = 1'b1;
        for (int k = 0; k < HOLD_WORDS; k++) send_random();
        tx_quiet = 1'b0;
      end
      for (int k = 0; k < WORDS_PER_PHASE; k++) begin
        if (ph == 4 && k == WORDS_PER_PHASE / 2) wait_drained();
        send_random();
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && words_in_flight == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/ipv_pkg.sv
sv/ipv_regs.sv
sv/incremental_pid_velocity_4ch_unit.sv
test/ipv_drive_checker.sv
test/incremental_pid_velocity_4ch_unit_tb.sv
